// ----- hdl/plcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcl_pkg
// Shared types and constants for the polygon side crossing unit.
// ----------------------------------------------------------------------------
package plcl_pkg;

	localparam int MAX_VERT  = 64;
	localparam int VIDX_W    = $clog2(MAX_VERT);
	localparam int CNT_W     = $clog2(MAX_VERT + 1);
	localparam int COORD_W   = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int TOL_W     = 16;
	localparam int MUL_A_W   = 18;
	localparam int MUL_B_W   = 36;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int Q_W       = 16;
	localparam int DIV_N_W   = 52;
	localparam int DIV_D_W   = 36;
	localparam int DIST_W    = 2 * DIFF_W + 1;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_FULL = 2'd1,
		STS_FEW  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RDI, ST_RDJ, ST_DIF,
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
		ST_NORM, ST_LO, ST_HI, ST_CHK, ST_NX, ST_NY,
		ST_DIVX, ST_DIVY, ST_SQX, ST_SQY, ST_UPD, ST_NEXT, ST_FIN
	} state_t;

	typedef struct packed {
		logic                done;
		logic [Q_W-1:0]      quot;
	} div_res_t;

endpackage

// ----- hdl/plcl_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcl_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module plcl_mul (
	input  logic                                 clk,
	input  logic signed [plcl_pkg::MUL_A_W-1:0]  a,
	input  logic signed [plcl_pkg::MUL_B_W-1:0]  b,
	output logic signed [plcl_pkg::MUL_P_W-1:0]  p_q
);
	import plcl_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- hdl/plcl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcl_div
// Restoring divider, one quotient bit per cycle; quotient below 2^Q_W.
// ----------------------------------------------------------------------------
module plcl_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [plcl_pkg::DIV_N_W-1:0]      num,
	input  logic [plcl_pkg::DIV_D_W-1:0]      den,
	output plcl_pkg::div_res_t                res
);
	import plcl_pkg::*;

	localparam int CW = $clog2(Q_W + 1);

	logic [DIV_N_W-1:0] rem_q;
	logic [DIV_N_W-1:0] dsh_q;
	logic [Q_W-1:0]     quot_q;
	logic [CW-1:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(Q_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= DIV_N_W'(den) << (Q_W - 1);
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			if (rem_q >= dsh_q) begin
				rem_q  <= rem_q - dsh_q;
				quot_q <= {quot_q[Q_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[Q_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign res.done = (cnt_q == '0);
	assign res.quot = quot_q;

endmodule

// ----- hdl/polygon_line_closest_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_line_closest_intersection
// Polygon vertex store with segment-against-sides crossing query.
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   opcode, first_x/y, second_x/y, ignore_*,
//                                   find_closest
// out      out  out_valid/out_stall status, hit, side_index, hit_x/y,
//                                   vertex_count
// cfg      in   cfg_we              cfg_wdata (tolerance)
//
// Clear, append and no-op pass straight to the result. A query visits the
// sides in turn (a skipped side, or one with a zero denominator or failing
// the range test, stops early); the two divisions of the hit point dominate.
// One multiplier serves all products and one divider both divisions.
// Reset clears the count and tolerance; the vertex store is not cleared.
// in_stall is high from acceptance until the result goes to the out register.
module polygon_line_closest_intersection (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [plcl_pkg::TOL_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic signed [plcl_pkg::COORD_W-1:0] first_x,
	input  logic signed [plcl_pkg::COORD_W-1:0] first_y,
	input  logic signed [plcl_pkg::COORD_W-1:0] second_x,
	input  logic signed [plcl_pkg::COORD_W-1:0] second_y,
	input  logic                                ignore_valid,
	input  logic [plcl_pkg::VIDX_W-1:0]         ignore_index,
	input  logic                                find_closest,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic                                hit,
	output logic [plcl_pkg::VIDX_W-1:0]         side_index,
	output logic signed [plcl_pkg::COORD_W-1:0] hit_x,
	output logic signed [plcl_pkg::COORD_W-1:0] hit_y,
	output logic [plcl_pkg::CNT_W-1:0]          vertex_count
);
	import plcl_pkg::*;

	state_t st_q, st_d;

	logic [TOL_W-1:0]          tol_q;
	logic signed [COORD_W-1:0] mem_x [MAX_VERT];
	logic signed [COORD_W-1:0] mem_y [MAX_VERT];
	logic signed [COORD_W-1:0] rd_x_q, rd_y_q;
	logic [VIDX_W-1:0]         rd_addr;
	logic [CNT_W-1:0]          cnt_q, i_q, i_nx, j_idx;

	logic signed [COORD_W-1:0] x1_q, y1_q, x3_q, y3_q;
	logic signed [DIFF_W-1:0]  dx12_q, dy12_q, dx34_q, dy34_q, e13x_q, e13y_q;
	logic                      ign_q, closest_q;
	logic [VIDX_W-1:0]         ign_idx_q;

	logic signed [MUL_B_W-1:0] acc_q, den_q, na_q, nb_q;
	logic signed [MUL_P_W-1:0] lo_q, numx_q, numy_q, nas, nbs;
	logic signed [DIFF_W-1:0]  qx_q, qy_q, q_mag, q_sgn;
	logic [DIST_W-2:0]         sq_q;
	logic [DIST_W-1:0]         cand_d, best_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] p_q;
	logic signed [MUL_P_W-1:0] num_sel, num_abs;

	logic                      div_start;
	div_res_t                  div_res;

	logic                      acc_in, skip, pass, out_load;

	status_t                   res_status_q;
	logic                      res_hit_q;
	logic [VIDX_W-1:0]         res_side_q;
	logic signed [COORD_W-1:0] res_hx_q, res_hy_q;

	plcl_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	plcl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_abs[DIV_N_W-1:0]),
		.den    (den_q),
		.res    (div_res)
	);

	assign acc_in = in_valid && !in_stall;
	assign i_nx   = i_q + CNT_W'(1);
	assign j_idx  = (i_nx < cnt_q) ? i_nx : '0;
	assign skip   = ign_q && (i_q[VIDX_W-1:0] == ign_idx_q ||
		j_idx[VIDX_W-1:0] == ign_idx_q);
	assign nas    = MUL_P_W'(signed'({na_q, 16'b0}));
	assign nbs    = MUL_P_W'(signed'({nb_q, 16'b0}));
	assign pass   = !(nas < lo_q) && !(nas > p_q) && !(nbs < lo_q) && !(nbs > p_q);
	assign cand_d = {1'b0, sq_q} + {1'b0, p_q[DIST_W-2:0]};
	assign out_load = (st_q == ST_FIN) && (!out_valid || !out_stall);
	assign num_abs  = num_sel[MUL_P_W-1] ? -num_sel : num_sel;
	assign q_mag    = signed'({1'b0, div_res.quot});

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (acc_in) begin
					if (op_t'(opcode) == OP_QUERY && cnt_q >= CNT_W'(3))
						st_d = ST_RDI;
					else
						st_d = ST_FIN;
				end
			end
			ST_RDI:  st_d = skip ? ST_NEXT : ST_RDJ;
			ST_RDJ:  st_d = ST_DIF;
			ST_DIF:  st_d = ST_M1;
			ST_M1:   st_d = ST_M2;
			ST_M2:   st_d = ST_M3;
			ST_M3:   st_d = ST_M4;
			ST_M4:   st_d = ST_M5;
			ST_M5:   st_d = ST_M6;
			ST_M6:   st_d = ST_M7;
			ST_M7:   st_d = ST_NORM;
			ST_NORM: st_d = (den_q == '0) ? ST_NEXT : ST_LO;
			ST_LO:   st_d = ST_HI;
			ST_HI:   st_d = ST_CHK;
			ST_CHK:  st_d = pass ? ST_NX : ST_NEXT;
			ST_NX:   st_d = ST_NY;
			ST_NY:   st_d = ST_DIVX;
			ST_DIVX: if (div_res.done) st_d = ST_DIVY;
			ST_DIVY: if (div_res.done) st_d = ST_SQX;
			ST_SQX:  st_d = ST_SQY;
			ST_SQY:  st_d = ST_UPD;
			ST_UPD:  st_d = closest_q ? ST_NEXT : ST_FIN;
			ST_NEXT: st_d = (i_nx >= cnt_q) ? ST_FIN : ST_RDI;
			ST_FIN:  if (out_load) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (st_q != ST_IDLE);
		rd_addr   = (st_q == ST_RDJ) ? j_idx[VIDX_W-1:0] : i_q[VIDX_W-1:0];
		div_start = (st_q == ST_NY) || (st_q == ST_DIVX && div_res.done);
		num_sel   = (st_q == ST_NY) ? numx_q : numy_q;
		mul_a     = MUL_A_W'(dy34_q);
		mul_b     = MUL_B_W'(dx12_q);
		unique case (st_q)
			ST_M2: begin mul_a = MUL_A_W'(dx34_q); mul_b = MUL_B_W'(dy12_q); end
			ST_M3: begin mul_a = MUL_A_W'(dx34_q); mul_b = MUL_B_W'(e13y_q); end
			ST_M4: begin mul_a = MUL_A_W'(dy34_q); mul_b = MUL_B_W'(e13x_q); end
			ST_M5: begin mul_a = MUL_A_W'(dx12_q); mul_b = MUL_B_W'(e13y_q); end
			ST_M6: begin mul_a = MUL_A_W'(dy12_q); mul_b = MUL_B_W'(e13x_q); end
			ST_LO: begin mul_a = signed'({2'b00, tol_q}); mul_b = den_q; end
			ST_HI: begin
				mul_a = MUL_A_W'(65536) - signed'({2'b00, tol_q});
				mul_b = den_q;
			end
			ST_CHK: begin mul_a = MUL_A_W'(dx12_q); mul_b = na_q; end
			ST_NX:  begin mul_a = MUL_A_W'(dy12_q); mul_b = na_q; end
			ST_SQX: begin mul_a = MUL_A_W'(qx_q); mul_b = MUL_B_W'(qx_q); end
			ST_SQY: begin mul_a = MUL_A_W'(qy_q); mul_b = MUL_B_W'(qy_q); end
			default: ;
		endcase
	end

	always_comb begin
		q_sgn = ((st_q == ST_DIVX) ? numx_q[MUL_P_W-1] : numy_q[MUL_P_W-1]) ?
			-q_mag : q_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			tol_q     <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we)
				tol_q <= cfg_wdata;
			if (acc_in) begin
				unique case (op_t'(opcode))
					OP_CLEAR:  cnt_q <= '0;
					OP_APPEND: if (cnt_q != CNT_W'(MAX_VERT)) cnt_q <= cnt_q + CNT_W'(1);
					OP_QUERY:  ;
					OP_NOP:    ;
				endcase
			end
			if (out_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && op_t'(opcode) == OP_APPEND && cnt_q != CNT_W'(MAX_VERT)) begin
			mem_x[cnt_q[VIDX_W-1:0]] <= first_x;
			mem_y[cnt_q[VIDX_W-1:0]] <= first_y;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				x1_q      <= first_x;
				y1_q      <= first_y;
				dx12_q    <= DIFF_W'(second_x) - DIFF_W'(first_x);
				dy12_q    <= DIFF_W'(second_y) - DIFF_W'(first_y);
				ign_q     <= ignore_valid;
				ign_idx_q <= ignore_index;
				closest_q <= find_closest;
				i_q       <= '0;
				res_hit_q  <= 1'b0;
				res_side_q <= '0;
				res_hx_q   <= '0;
				res_hy_q   <= '0;
				best_q     <= '0;
				res_status_q <= STS_OK;
				if (op_t'(opcode) == OP_APPEND && cnt_q == CNT_W'(MAX_VERT))
					res_status_q <= STS_FULL;
				else if (op_t'(opcode) == OP_QUERY && cnt_q < CNT_W'(3))
					res_status_q <= STS_FEW;
			end
			ST_RDJ: begin
				x3_q <= rd_x_q;
				y3_q <= rd_y_q;
			end
			ST_DIF: begin
				dx34_q <= DIFF_W'(rd_x_q) - DIFF_W'(x3_q);
				dy34_q <= DIFF_W'(rd_y_q) - DIFF_W'(y3_q);
				e13x_q <= DIFF_W'(x1_q) - DIFF_W'(x3_q);
				e13y_q <= DIFF_W'(y1_q) - DIFF_W'(y3_q);
			end
			ST_M2: acc_q <= p_q[MUL_B_W-1:0];
			ST_M3: den_q <= acc_q - p_q[MUL_B_W-1:0];
			ST_M4: acc_q <= p_q[MUL_B_W-1:0];
			ST_M5: na_q  <= acc_q - p_q[MUL_B_W-1:0];
			ST_M6: acc_q <= p_q[MUL_B_W-1:0];
			ST_M7: nb_q  <= acc_q - p_q[MUL_B_W-1:0];
			ST_NORM: begin
				if (den_q < 0) begin
					den_q <= -den_q;
					na_q  <= -na_q;
					nb_q  <= -nb_q;
				end
			end
			ST_HI:   lo_q   <= p_q;
			ST_NX:   numx_q <= p_q;
			ST_NY:   numy_q <= p_q;
			ST_DIVX: if (div_res.done) qx_q <= q_sgn;
			ST_DIVY: if (div_res.done) qy_q <= q_sgn;
			ST_SQY:  sq_q <= p_q[DIST_W-2:0];
			ST_UPD: begin
				if (!res_hit_q || cand_d < best_q) begin
					res_hit_q  <= 1'b1;
					best_q     <= cand_d;
					res_side_q <= i_q[VIDX_W-1:0];
					res_hx_q   <= x1_q + qx_q[COORD_W-1:0];
					res_hy_q   <= y1_q + qy_q[COORD_W-1:0];
				end
			end
			ST_NEXT: i_q <= i_nx;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status       <= res_status_q;
			hit          <= res_hit_q;
			side_index   <= res_side_q;
			hit_x        <= res_hx_q;
			hit_y        <= res_hy_q;
			vertex_count <= cnt_q;
		end
	end

endmodule

// ----- hdl/plcl_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcl_chk
// Port-level checks for the polygon side crossing unit.
// ----------------------------------------------------------------------------
module plcl_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [1:0]                          status,
	input logic                                hit,
	input logic [plcl_pkg::VIDX_W-1:0]         side_index,
	input logic signed [plcl_pkg::COORD_W-1:0] hit_x,
	input logic signed [plcl_pkg::COORD_W-1:0] hit_y,
	input logic [plcl_pkg::CNT_W-1:0]          vertex_count
);
	import plcl_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hit_x) && $stable(hit_y) && $stable(status))
		else $error("stalled result changed");

	a_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> side_index == '0 && hit_x == '0 && hit_y == '0)
		else $error("miss carries nonzero point");

	a_few: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STS_FEW |-> !hit && vertex_count < CNT_W'(3))
		else $error("short polygon status wrong");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STS_FULL |-> vertex_count == CNT_W'(MAX_VERT) && !hit)
		else $error("full status with room left");

endmodule

bind polygon_line_closest_intersection plcl_chk u_plcl_chk (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the polygon side crossing unit. A directed table
// covers reset state, coordinate extremes, the ignored vertex, parallel sides,
// no-op and clear; a full store comes next. Random polygons with random segment
// queries follow over several tolerance settings and idle/stall phases. Each
// result is checked against the table or an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;
	import plcl_pkg::*;

	localparam int CYC_LIMIT = 10000000;

	typedef struct packed {
		op_t                       opcode;
		logic signed [COORD_W-1:0] fx;
		logic signed [COORD_W-1:0] fy;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic                      ign_v;
		logic [VIDX_W-1:0]         ign_i;
		logic                      closest;
	} item_t;

	typedef struct packed {
		status_t                   status;
		logic                      hit;
		logic [VIDX_W-1:0]         side;
		logic signed [COORD_W-1:0] hx;
		logic signed [COORD_W-1:0] hy;
		logic [CNT_W-1:0]          cnt;
	} res_t;

	typedef struct {
		item_t it;
		bit    typed;
		res_t  res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [TOL_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	item_t in_item = '0;
	logic in_stall, out_valid;
	logic [1:0] status;
	logic hit;
	logic [VIDX_W-1:0] side_index;
	logic signed [COORD_W-1:0] hit_x, hit_y;
	logic [CNT_W-1:0] vertex_count;

	// predictor state
	longint poly_x[MAX_VERT];
	longint poly_y[MAX_VERT];
	int unsigned poly_cnt = 0;
	longint tol_val = 0;

	res_t result_q[$];
	int errs = 0;
	int unsigned cyc = 0;
	int unsigned snd_idle = 0;
	int unsigned rcv_stall = 0;
	dir_row_t dir_tab[13];

	polygon_line_closest_intersection u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(in_item.opcode), .first_x(in_item.fx), .first_y(in_item.fy),
		.second_x(in_item.sx), .second_y(in_item.sy),
		.ignore_valid(in_item.ign_v), .ignore_index(in_item.ign_i),
		.find_closest(in_item.closest),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .hit(hit), .side_index(side_index),
		.hit_x(hit_x), .hit_y(hit_y), .vertex_count(vertex_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYC_LIMIT) begin
			$display("** polygon_line_closest_intersection: FAILED **");
			$finish;
		end
	end

	function automatic bit side_cross(input longint x1, y1, x2, y2, x3, y3, x4, y4,
			output longint px, output longint py);
		longint dx12, dy12, dx34, dy34, den, na, nb, lo, hi;
		dx12 = x2 - x1; dy12 = y2 - y1;
		dx34 = x4 - x3; dy34 = y4 - y3;
		den = dy34 * dx12 - dx34 * dy12;
		na = dx34 * (y1 - y3) - dy34 * (x1 - x3);
		nb = dx12 * (y1 - y3) - dy12 * (x1 - x3);
		px = 0; py = 0;
		if (den == 0)
			return 1'b0;
		if (den < 0) begin
			den = -den; na = -na; nb = -nb;
		end
		lo = tol_val * den;
		hi = (64'sd65536 - tol_val) * den;
		if (na * 65536 < lo || na * 65536 > hi)
			return 1'b0;
		if (nb * 65536 < lo || nb * 65536 > hi)
			return 1'b0;
		px = x1 + (na * dx12) / den;
		py = y1 + (na * dy12) / den;
		return 1'b1;
	endfunction

	function automatic res_t poly_eval(input item_t it);
		res_t r;
		longint ax, ay, bx, by, px, py, ddx, ddy, hx, hy;
		longint unsigned d, best;
		int unsigned j;
		bit found;
		r = '0;
		found = 1'b0;
		best = 0; hx = 0; hy = 0;
		ax = it.fx; ay = it.fy; bx = it.sx; by = it.sy;
		case (it.opcode)
			OP_CLEAR: poly_cnt = 0;
			OP_APPEND: begin
				if (poly_cnt >= MAX_VERT) begin
					r.status = STS_FULL;
				end else begin
					poly_x[poly_cnt] = ax;
					poly_y[poly_cnt] = ay;
					poly_cnt++;
				end
			end
			OP_QUERY: begin
				if (poly_cnt < 3) begin
					r.status = STS_FEW;
				end else begin
					for (int unsigned i = 0; i < poly_cnt; i++) begin
						j = (i + 1 < poly_cnt) ? i + 1 : 0;
						if (it.ign_v && (i == it.ign_i || j == it.ign_i))
							continue;
						if (side_cross(ax, ay, bx, by, poly_x[i], poly_y[i],
								poly_x[j], poly_y[j], px, py)) begin
							ddx = px - ax; ddy = py - ay;
							d = longint'(ddx * ddx) + longint'(ddy * ddy);
							if (!found || d < best) begin
								found = 1'b1;
								best = d;
								r.side = i[VIDX_W-1:0];
								hx = px; hy = py;
							end
							if (!it.closest)
								break;
						end
					end
				end
			end
			default: ;
		endcase
		r.hit = found;
		r.hx = hx[COORD_W-1:0];
		r.hy = hy[COORD_W-1:0];
		r.cnt = poly_cnt[CNT_W-1:0];
		return r;
	endfunction

	function automatic item_t mk(input op_t op, input int fx, fy, sx, sy,
			input int iv, input int ii, input int fc);
		item_t it;
		it.opcode = op;
		it.fx = fx[COORD_W-1:0]; it.fy = fy[COORD_W-1:0];
		it.sx = sx[COORD_W-1:0]; it.sy = sy[COORD_W-1:0];
		it.ign_v = iv[0]; it.ign_i = ii[VIDX_W-1:0]; it.closest = fc[0];
		return it;
	endfunction

	function automatic res_t plain(input status_t st, input int cnt);
		res_t r;
		r = '0;
		r.status = st;
		r.cnt = cnt[CNT_W-1:0];
		return r;
	endfunction

	task automatic send_item(input item_t it, input bit typed, input res_t tres);
		res_t r;
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = poly_eval(it);
		result_q = {result_q, (typed ? tres : r)};
	endtask

	task automatic send_checked(input item_t it);
		send_item(it, 1'b0, '0);
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [TOL_W-1:0] v);
		drain_all();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_val = v;
	endtask

	function automatic int rnd_full();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	function automatic int rnd_near(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic random_phase(input int n_items);
		int sent, k, nq, kind;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 85) begin
				send_checked(mk(OP_CLEAR, rnd_full(), rnd_full(), rnd_full(), rnd_full(),
					$urandom_range(1), $urandom_range(63), $urandom_range(1)));
				k = $urandom_range(99);
				if (k < 80) k = $urandom_range(3, 8);
				else if (k < 95) k = $urandom_range(0, 2);
				else k = $urandom_range(9, 64);
				for (int i = 0; i < k; i++)
					send_checked(mk(OP_APPEND, rnd_near(2000), rnd_near(2000),
						rnd_full(), rnd_full(), $urandom_range(1),
						$urandom_range(63), $urandom_range(1)));
				nq = $urandom_range(1, 6);
				for (int i = 0; i < nq; i++)
					send_checked(mk(OP_QUERY, rnd_near(3000), rnd_near(3000),
						rnd_near(3000), rnd_near(3000), $urandom_range(1),
						$urandom_range(k + 1), $urandom_range(1)));
				sent += k + nq + 1;
			end else begin
				send_checked(mk(op_t'($urandom_range(3)), rnd_full(), rnd_full(),
					rnd_full(), rnd_full(), $urandom_range(1), $urandom_range(63),
					$urandom_range(1)));
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		res_t e;
		if (out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$error("result with nothing expected");
				errs++;
			end else begin
				e = result_q.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status); errs++;
				end
				if (hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, hit); errs++;
				end
				if (side_index !== e.side) begin
					$error("side_index: expected %0d, got %0d", e.side, side_index); errs++;
				end
				if (hit_x !== e.hx) begin
					$error("hit_x: expected %0d, got %0d", e.hx, hit_x); errs++;
				end
				if (hit_y !== e.hy) begin
					$error("hit_y: expected %0d, got %0d", e.hy, hit_y); errs++;
				end
				if (vertex_count !== e.cnt) begin
					$error("vertex_count: expected %0d, got %0d", e.cnt, vertex_count);
					errs++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < rcv_stall);
	end

	initial begin
		dir_tab[0]  = '{mk(OP_QUERY, 0, 0, 100, 100, 0, 0, 0), 1, plain(STS_FEW, 0)};
		dir_tab[1]  = '{mk(OP_APPEND, -32768, -32768, 0, 0, 0, 0, 0), 1, plain(STS_OK, 1)};
		dir_tab[2]  = '{mk(OP_APPEND, 32767, -32768, 0, 0, 0, 0, 0), 1, plain(STS_OK, 2)};
		dir_tab[3]  = '{mk(OP_QUERY, 0, -32768, 0, 32767, 1, 63, 1), 1, plain(STS_FEW, 2)};
		dir_tab[4]  = '{mk(OP_APPEND, 0, 32767, 0, 0, 0, 0, 0), 1, plain(STS_OK, 3)};
		dir_tab[5]  = '{mk(OP_QUERY, -32768, 0, 32767, 0, 0, 0, 0), 0, '0};
		dir_tab[6]  = '{mk(OP_QUERY, -32768, 0, 32767, 0, 0, 0, 1), 0, '0};
		dir_tab[7]  = '{mk(OP_QUERY, 0, -32768, 0, 32767, 0, 0, 1), 0, '0};
		dir_tab[8]  = '{mk(OP_QUERY, -32768, 0, 32767, 0, 1, 0, 1), 0, '0};
		dir_tab[9]  = '{mk(OP_QUERY, -32768, 0, 32767, 0, 1, 63, 1), 0, '0};
		dir_tab[10] = '{mk(OP_QUERY, -100, -32768, 100, -32768, 0, 0, 1), 0, '0};
		dir_tab[11] = '{mk(OP_NOP, 32767, 32767, -1, -1, 1, 63, 1), 1, plain(STS_OK, 3)};
		dir_tab[12] = '{mk(OP_CLEAR, -1, -1, -1, -1, 1, 63, 1), 1, plain(STS_OK, 0)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
		for (int i = 0; i < MAX_VERT; i++)
			send_checked(mk(OP_APPEND, rnd_near(3000), rnd_near(3000), 0, 0, 0, 0, 0));
		send_item(mk(OP_APPEND, 5, 5, 0, 0, 0, 0, 0), 1'b1, plain(STS_FULL, MAX_VERT));
		send_checked(mk(OP_QUERY, -4000, -4000, 4000, 4000, 0, 0, 1));

		random_phase(80);
		set_tolerance(16'd32768);
		snd_idle = 61; rcv_stall = 0;
		random_phase(50);
		set_tolerance(16'($urandom_range(4000)));
		snd_idle = 0; rcv_stall = 61;
		random_phase(80);
		set_tolerance(16'hFFFF);
		snd_idle = 22; rcv_stall = 22;
		random_phase(30);
		set_tolerance(16'($urandom_range(1, 600)));
		random_phase(80);

		drain_all();
		repeat (20) @(posedge clk);
		if (errs == 0)
			$display("** polygon_line_closest_intersection: PASSED **");
		else
			$display("** polygon_line_closest_intersection: FAILED **");
		$finish;
	end
endmodule
